// ===== rtl/core/cmfp_pkg.sv =====
`timescale 1ns / 1ps

package cmfp_pkg;

  localparam int unsigned COMPONENT_BITS_DEF = 24;
  localparam int unsigned FRACTION_BITS_DEF  = 16;
  localparam int unsigned THRESH_W           = 48;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_e;

endpackage

// ===== rtl/core/cmfp_ratio_pipe.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider for one face coordinate. The numerator is never
// larger than the denominator, so the quotient num * 2^F / den fits in F+1 bits
// and never exceeds one. One quotient bit is resolved per stage, then the sign
// is applied in a last stage.
module cmfp_ratio_pipe #(
  parameter int unsigned COMPONENT_BITS = cmfp_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned FRACTION_BITS  = cmfp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic [COMPONENT_BITS-1:0]            num_i,
  input  logic [COMPONENT_BITS-1:0]            den_i,
  input  logic                                 neg_i,
  output logic signed [FRACTION_BITS+1:0]      coord_o
);

  import cmfp_pkg::*;

  localparam int unsigned CB    = COMPONENT_BITS;
  localparam int unsigned F     = FRACTION_BITS;
  localparam int unsigned Steps = F + 1;

  logic [CB:0]   rem_q [Steps-1];
  logic [CB-1:0] den_q [Steps-1];
  logic [F:0]    quo_q [Steps];
  logic          neg_q [Steps];

  logic signed [F+1:0] coord_q;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [CB:0]   rem_in;
    logic [CB-1:0] den_in;
    logic [F:0]    quo_in;
    logic          neg_in;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign ge = rem_in >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      quo_q[k] <= {quo_in[F-1:0], ge};
      neg_q[k] <= neg_in;
    end

    if (k < Steps - 1) begin : g_carry
      logic [CB-1:0] diff;
      logic [CB-1:0] keep;

      // After a subtraction the remainder is below the denominator, so its top bit is clear.
      assign diff = rem_in[CB-1:0] - den_in;
      assign keep = ge ? diff : rem_in[CB-1:0];

      always_ff @(posedge clk_i) begin
        rem_q[k] <= {keep, 1'b0};
        den_q[k] <= den_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (neg_q[Steps-1]) begin
      coord_q <= -$signed({1'b0, quo_q[Steps-1]});
    end else begin
      coord_q <= $signed({1'b0, quo_q[Steps-1]});
    end
  end

  assign coord_o = coord_q;

endmodule

// ===== rtl/core/cube_map_face_projection_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// command   in         start, busy               dir_x_i, dir_y_i, dir_z_i
// result    out        done_o (one-cycle strobe) face_o, u_coord_o, v_coord_o
// config    in         zero_threshold_we_i       zero_threshold_i
//
// One beat is accepted every cycle; busy never rises. A result strobes out once
// its command beat has passed the input stages, the divider pipeline that
// resolves one quotient bit per stage and the output register. Reset clears the
// valid bits and the threshold register. The receiver cannot stall, so the pipeline always advances.
module cube_map_face_projection_core #(
  parameter int unsigned COMPONENT_BITS = cmfp_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned FRACTION_BITS  = cmfp_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COMPONENT_BITS-1:0]  dir_x_i,
  input  logic signed [COMPONENT_BITS-1:0]  dir_y_i,
  input  logic signed [COMPONENT_BITS-1:0]  dir_z_i,
  input  logic                              zero_threshold_we_i,
  input  logic [cmfp_pkg::THRESH_W-1:0]     zero_threshold_i,
  output logic                              done_o,
  output cmfp_pkg::face_e                   face_o,
  output logic signed [FRACTION_BITS+1:0]   u_coord_o,
  output logic signed [FRACTION_BITS+1:0]   v_coord_o
);

  import cmfp_pkg::*;

  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned LW = 2 * CB + 2;
  localparam int unsigned CW = (LW > THRESH_W) ? LW : THRESH_W;

  logic [THRESH_W-1:0] thr_q;

  // Stage 1: magnitudes and signs.
  logic          v1_q;
  logic [CB-1:0] mag_x_q, mag_y_q, mag_z_q;
  logic          neg_x_q, neg_y_q, neg_z_q;
  logic [CB-1:0] mag_x_d, mag_y_d, mag_z_d;

  // Stage 2: squares, major axis, divider operands.
  logic            v2_q;
  logic [2*CB-1:0] sq_x_q, sq_y_q, sq_z_q;
  face_e           face2_q, face2_d;
  logic [CB-1:0]   num_u_q, num_v_q, den_q;
  logic            neg_u_q, neg_v_q;
  logic [CB-1:0]   num_u_d, num_v_d, den_d;
  logic            neg_u_d, neg_v_d;

  // Stage 3: squared length.  Stage 4: fallback decision.
  logic          v3_q, v4_q;
  face_e         face3_q, face4_q;
  logic [LW-1:0] len2_q;
  logic          fb4_q;

  // Sideband delay line matching the divider latency.
  logic  dly_valid_q [F];
  face_e dly_face_q  [F];
  logic  dly_fb_q    [F];

  logic                done_q;
  face_e               face_q;
  logic signed [F+1:0] u_q, v_q;
  logic signed [F+1:0] u_div, v_div;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (zero_threshold_we_i) begin
      thr_q <= zero_threshold_i;
    end
  end

  // The most negative code keeps its magnitude, which fits as an unsigned value.
  assign mag_x_d = dir_x_i[CB-1] ? (~dir_x_i + CB'(1)) : dir_x_i;
  assign mag_y_d = dir_y_i[CB-1] ? (~dir_y_i + CB'(1)) : dir_y_i;
  assign mag_z_d = dir_z_i[CB-1] ? (~dir_z_i + CB'(1)) : dir_z_i;

  always_comb begin
    logic x_major;
    logic y_major;
    logic flip_u;
    logic flip_v;
    logic nu_neg;
    logic nv_neg;
    logic d_neg;
    x_major = (mag_x_q >= mag_y_q) && (mag_x_q >= mag_z_q);
    y_major = !x_major && (mag_y_q >= mag_z_q);
    flip_u  = 1'b0;
    flip_v  = 1'b0;
    if (x_major) begin
      face2_d = neg_x_q ? FACE_NEG_X : FACE_POS_X;
      num_u_d = mag_z_q;
      nu_neg  = neg_z_q;
      num_v_d = mag_y_q;
      nv_neg  = neg_y_q;
      den_d   = mag_x_q;
      d_neg   = neg_x_q;
      flip_v  = neg_x_q;
    end else if (y_major) begin
      face2_d = neg_y_q ? FACE_NEG_Y : FACE_POS_Y;
      num_u_d = mag_x_q;
      nu_neg  = neg_x_q;
      num_v_d = mag_z_q;
      nv_neg  = neg_z_q;
      den_d   = mag_y_q;
      d_neg   = neg_y_q;
      flip_u  = neg_y_q;
    end else begin
      face2_d = neg_z_q ? FACE_NEG_Z : FACE_POS_Z;
      num_u_d = mag_x_q;
      nu_neg  = neg_x_q;
      num_v_d = mag_y_q;
      nv_neg  = neg_y_q;
      den_d   = mag_z_q;
      d_neg   = neg_z_q;
      flip_v  = neg_z_q;
    end
    neg_u_d = nu_neg ^ d_neg ^ flip_u;
    neg_v_d = nv_neg ^ d_neg ^ flip_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      done_q <= 1'b0;
      for (int i = 0; i < F; i++) begin
        dly_valid_q[i] <= 1'b0;
      end
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      dly_valid_q[0] <= v4_q;
      for (int i = 1; i < F; i++) begin
        dly_valid_q[i] <= dly_valid_q[i-1];
      end
      done_q <= dly_valid_q[F-1];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_x_q <= mag_x_d;
    mag_y_q <= mag_y_d;
    mag_z_q <= mag_z_d;
    neg_x_q <= dir_x_i[CB-1];
    neg_y_q <= dir_y_i[CB-1];
    neg_z_q <= dir_z_i[CB-1];

    sq_x_q  <= mag_x_q * mag_x_q;
    sq_y_q  <= mag_y_q * mag_y_q;
    sq_z_q  <= mag_z_q * mag_z_q;
    face2_q <= face2_d;
    num_u_q <= num_u_d;
    num_v_q <= num_v_d;
    den_q   <= den_d;
    neg_u_q <= neg_u_d;
    neg_v_q <= neg_v_d;

    len2_q  <= LW'(sq_x_q) + LW'(sq_y_q) + LW'(sq_z_q);
    face3_q <= face2_q;

    fb4_q   <= CW'(len2_q) <= CW'(thr_q);
    face4_q <= face3_q;

    dly_face_q[0] <= face4_q;
    dly_fb_q[0]   <= fb4_q;
    for (int i = 1; i < F; i++) begin
      dly_face_q[i] <= dly_face_q[i-1];
      dly_fb_q[i]   <= dly_fb_q[i-1];
    end

    // A short vector falls back to +Y with both coordinates zero.
    if (dly_fb_q[F-1]) begin
      face_q <= FACE_POS_Y;
      u_q    <= '0;
      v_q    <= '0;
    end else begin
      face_q <= dly_face_q[F-1];
      u_q    <= u_div;
      v_q    <= v_div;
    end
  end

  cmfp_ratio_pipe #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_ratio_u (
    .clk_i   (clk_i),
    .num_i   (num_u_q),
    .den_i   (den_q),
    .neg_i   (neg_u_q),
    .coord_o (u_div)
  );

  cmfp_ratio_pipe #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_ratio_v (
    .clk_i   (clk_i),
    .num_i   (num_v_q),
    .den_i   (den_q),
    .neg_i   (neg_v_q),
    .coord_o (v_div)
  );

  assign done_o    = done_q;
  assign face_o    = face_q;
  assign u_coord_o = u_q;
  assign v_coord_o = v_q;

endmodule

// ===== dv/cube_map_face_projection_core_test.sv =====
`timescale 1ns / 1ps

module cube_map_face_projection_core_test;
  import cmfp_pkg::*;

  localparam int unsigned CB = COMPONENT_BITS_DEF;
  localparam int unsigned FB = FRACTION_BITS_DEF;
  localparam int unsigned CW = FB + 2;
  localparam int unsigned LATENCY = FB + 4;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [CB-1:0] MIN_COMP = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] MAX_COMP = {1'b0, {(CB-1){1'b1}}};
  localparam logic [THRESH_W-1:0] THRESH_MAX = '1;

  typedef logic signed [CB-1:0] comp_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_DIR,
    OP_THRESH,
    OP_DRAIN
  } cmd_op_e;

  typedef struct {
    cmd_op_e             op;
    comp_t               x;
    comp_t               y;
    comp_t               z;
    logic [THRESH_W-1:0] thresh;
    int                  gap;
  } cmd_t;

  typedef struct packed {
    logic          neg;
    logic [CB-1:0] mag;
  } axis_t;

  typedef struct {
    face_e  face;
    coord_t u;
    coord_t v;
  } projection_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  comp_t               dir_x_i = '0;
  comp_t               dir_y_i = '0;
  comp_t               dir_z_i = '0;
  logic                zero_threshold_we_i = 1'b0;
  logic [THRESH_W-1:0] zero_threshold_i = '0;
  logic                done_o;
  face_e               face_o;
  coord_t              u_coord_o;
  coord_t              v_coord_o;

  cmd_t                cmd_queue[$];
  projection_t         projections_due[$];
  logic [THRESH_W-1:0] thresh_shadow = '0;
  int                  cmd_beats = 0;
  int                  issued = 0;
  int                  gap_left = 0;
  int                  calm_left = 0;
  int                  errors = 0;
  int                  cycles = 0;

  cube_map_face_projection_core DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .dir_x_i             (dir_x_i),
    .dir_y_i             (dir_y_i),
    .dir_z_i             (dir_z_i),
    .zero_threshold_we_i (zero_threshold_we_i),
    .zero_threshold_i    (zero_threshold_i),
    .done_o              (done_o),
    .face_o              (face_o),
    .u_coord_o           (u_coord_o),
    .v_coord_o           (v_coord_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic axis_t split_axis(comp_t c);
    axis_t a;
    a.neg = c[CB-1];
    // The most negative value has no positive twin in CB bits, but its
    // magnitude 2^(CB-1) still fits an unsigned CB-bit field.
    a.mag = a.neg ? (~c + 1'b1) : c;
    return a;
  endfunction

  function automatic coord_t face_ratio(axis_t num, axis_t den, logic flip);
    logic [CB+FB-1:0] q;
    coord_t c;
    if (num.mag == '0 || den.mag == '0) return '0;
    q = {num.mag, {FB{1'b0}}} / (CB+FB)'(den.mag);
    if (q > (CB+FB)'(1) << FB) q = (CB+FB)'(1) << FB;
    c = CW'(q);
    return (num.neg ^ den.neg ^ flip) ? -c : c;
  endfunction

  function automatic projection_t project_direction(comp_t x, comp_t y, comp_t z,
                                                    logic [THRESH_W-1:0] thresh);
    axis_t ax, ay, az;
    logic [2*CB+1:0] len2;
    projection_t p;
    ax = split_axis(x);
    ay = split_axis(y);
    az = split_axis(z);
    len2 = ax.mag * ax.mag + ay.mag * ay.mag + az.mag * az.mag;
    p = '{FACE_POS_Y, '0, '0};
    if (len2 <= thresh) begin
      p = '{FACE_POS_Y, '0, '0};
    end else if (ax.mag >= ay.mag && ax.mag >= az.mag) begin
      p.face = ax.neg ? FACE_NEG_X : FACE_POS_X;
      p.u = face_ratio(az, ax, 1'b0);
      p.v = face_ratio(ay, ax, ax.neg);
    end else if (ay.mag >= az.mag) begin
      p.face = ay.neg ? FACE_NEG_Y : FACE_POS_Y;
      p.u = face_ratio(ax, ay, ay.neg);
      p.v = face_ratio(az, ay, 1'b0);
    end else begin
      p.face = az.neg ? FACE_NEG_Z : FACE_POS_Z;
      p.u = face_ratio(ax, az, 1'b0);
      p.v = face_ratio(ay, az, az.neg);
    end
    return p;
  endfunction

  function automatic comp_t rand_comp(int min_shift);
    comp_t v;
    v = CB'($urandom);
    case ((min_shift > 0) ? 7 : $urandom_range(0, 7))
      0: v = MIN_COMP;
      1: v = MAX_COMP;
      2: v = '0;
      3: v = comp_t'($urandom_range(0, 6)) - comp_t'(3);
      default: v = v >>> $urandom_range(min_shift, CB - 1);
    endcase
    return v;
  endfunction

  task automatic add_dir(comp_t x, comp_t y, comp_t z);
    int gap;
    // Mostly random gaps, with occasional back-to-back runs.
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(15, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 8);
    end
    cmd_queue.push_back('{OP_DIR, x, y, z, '0, gap});
  endtask

  task automatic add_rand_dirs(int count, int min_shift);
    comp_t x, y, z;
    repeat (count) begin
      x = rand_comp(min_shift);
      y = rand_comp(min_shift);
      z = rand_comp(min_shift);
      // Force magnitude ties between axes now and then.
      case ($urandom_range(0, 7))
        0: y = $urandom_range(0, 1) ? x : -x;
        1: z = $urandom_range(0, 1) ? y : -y;
        2: z = $urandom_range(0, 1) ? x : -x;
        3: begin
          y = $urandom_range(0, 1) ? x : -x;
          z = $urandom_range(0, 1) ? x : -x;
        end
        default: ;
      endcase
      add_dir(x, y, z);
    end
  endtask

  task automatic add_thresh(logic [THRESH_W-1:0] value);
    cmd_queue.push_back('{OP_THRESH, '0, '0, '0, value, 0});
  endtask

  always @(negedge clk_i) begin : driver
    logic n_start;
    logic n_we;
    cmd_t head;
    n_start = start;
    n_we = 1'b0;
    if (rst_ni) begin
      if (start && cmd_beats == issued) n_start = 1'b0;
      if (!n_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() > 0) begin
          head = cmd_queue[0];
          case (head.op)
            OP_DIR: begin
              void'(cmd_queue.pop_front());
              dir_x_i <= head.x;
              dir_y_i <= head.y;
              dir_z_i <= head.z;
              n_start = 1'b1;
              issued++;
              gap_left = head.gap;
            end
            OP_THRESH: begin
              if (projections_due.size() == 0) begin
                void'(cmd_queue.pop_front());
                zero_threshold_i <= head.thresh;
                n_we = 1'b1;
              end
            end
            OP_DRAIN: begin
              if (projections_due.size() == 0) void'(cmd_queue.pop_front());
            end
            default: ;
          endcase
        end
      end
    end
    start <= n_start;
    zero_threshold_we_i <= n_we;
  end

  always @(posedge clk_i) begin : result_check
    projection_t due;
    if (rst_ni) begin
      if (done_o) begin
        if (projections_due.size() == 0) begin
          $error("result beat with no projection pending: face %0d u %0d v %0d",
                 face_o, u_coord_o, v_coord_o);
          errors++;
        end else begin
          due = projections_due.pop_front();
          if (face_o !== due.face) begin
            $error("face: expected %0d, got %0d", due.face, face_o);
            errors++;
          end
          if (u_coord_o !== due.u) begin
            $error("u_coord: expected %0d, got %0d", due.u, u_coord_o);
            errors++;
          end
          if (v_coord_o !== due.v) begin
            $error("v_coord: expected %0d, got %0d", due.v, v_coord_o);
            errors++;
          end
        end
      end
      if (zero_threshold_we_i) thresh_shadow = zero_threshold_i;
      if (start && !busy) begin
        projections_due.push_back(project_direction(dir_x_i, dir_y_i, dir_z_i,
                                                     thresh_shadow));
        cmd_beats <= cmd_beats + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // Axis-aligned faces, ties, extremes and the zero vector.
    add_dir(0, 0, 0);
    add_dir(1000, 0, 0);
    add_dir(-1000, 0, 0);
    add_dir(0, 1000, 0);
    add_dir(0, -1000, 0);
    add_dir(0, 0, 1000);
    add_dir(0, 0, -1000);
    add_dir(500, 500, 500);
    add_dir(-500, 500, -500);
    add_dir(100, -700, 700);
    add_dir(MAX_COMP, MAX_COMP, MAX_COMP);
    add_dir(MIN_COMP, MIN_COMP, MIN_COMP);
    add_dir(MIN_COMP, MAX_COMP, 0);
    add_dir(MAX_COMP, MIN_COMP, 3);
    add_dir(1, 0, 0);
    add_dir(0, 0, -1);
    add_dir(-1, 1, -1);
    add_dir(300, -200, 100);
    add_dir(-300, 200, -100);
    add_dir(1234, -4321, 77);
    add_dir(MIN_COMP, 1, -1);
    add_dir(5, -7, MAX_COMP);
    add_rand_dirs(150, 0);
    cmd_queue.push_back('{OP_DRAIN, '0, '0, '0, '0, 0});
    add_rand_dirs(150, 0);

    // Every direction falls back at the largest threshold.
    add_thresh(THRESH_MAX);
    add_rand_dirs(40, 0);

    // Squared length exactly on the threshold falls back; a component one LSB larger does not.
    add_thresh(THRESH_W'(1) << 40);
    add_dir(comp_t'(1) << 20, 0, 0);
    add_dir(0, -(comp_t'(1) << 20), 0);
    add_dir((comp_t'(1) << 20) + 1, 0, 0);
    add_dir(0, 0, -((comp_t'(1) << 20) + 1));
    add_rand_dirs(120, CB - 22);

    add_thresh(THRESH_W'({$urandom, $urandom}) >> $urandom_range(0, THRESH_W - 1));
    add_rand_dirs(60, 0);
    add_thresh(THRESH_W'({$urandom, $urandom}) >> $urandom_range(0, THRESH_W - 1));
    add_rand_dirs(60, CB - 22);

    add_thresh('0);
    add_rand_dirs(120, 0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || start || projections_due.size() != 0);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
